>>> rtl/assert_macros.svh
// Assertion macros shared by the line walker RTL.
// Needs signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/blw_pkg.sv
// Package for the line walker: widths, sequencer states, step control struct.
// No dependencies.
package blw_pkg;

  localparam int CANVAS_SIZE_DEF = 64;
  localparam int COORD_W         = 6;
  localparam int COLOR_W         = 8;
  localparam int ERR_W           = 9;
  localparam int IN_W            = 48;
  localparam int OUT_W           = 40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] dx;
    logic [COORD_W:0]   derr;
    logic               up;
  } walk_ctl_t;

endpackage

>>> rtl/bresenham_line_walker_unit.sv
// Bresenham line walker: one segment in, one pixel word per cycle out unless the output stalls.
// On accept the segment is registered; ST_SETUP derives the walk, then ST_WALK registers each pixel.
// A segment of n pixels (1..64) holds the unit until its last pixel is loaded;
// the walk runs one pixel per cycle through the single error-step unit while m_tready allows.
// Reset (synchronous, rst high) clears the sequencer and output valid.
// Depends on blw_pkg, blw_step, assert_macros.svh.
`include "assert_macros.svh"

module bresenham_line_walker_unit #(
  parameter int CANVAS_SIZE = blw_pkg::CANVAS_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // start_x[5:0] start_y[11:6] end_x[17:12] end_y[23:18] red[31:24] green[39:32] blue[47:40]
  input  logic [blw_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // pixel_x[5:0] pixel_y[11:6] out_red[19:12] out_green[27:20] out_blue[35:28] zero[39:36]
  output logic [blw_pkg::OUT_W-1:0]  m_tdata,
  // last_pixel
  output logic                       m_tlast
);
  import blw_pkg::*;

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(CANVAS_SIZE - 1);

  state_t state, state_next;

  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [COLOR_W-1:0] red, green, blue;
  logic [COORD_W-1:0] maj, mnr, end_maj;
  logic               steep;
  logic signed [ERR_W-1:0] err;
  walk_ctl_t          ctl;

  logic signed [ERR_W-1:0] err_next;
  logic [COORD_W-1:0] mnr_next;

  logic [COORD_W-1:0] adx, ady;
  logic               steep_w;
  logic [COORD_W-1:0] p0maj, p0mnr, p1maj, p1mnr;
  logic [COORD_W-1:0] smaj, smnr, emaj, emnr;

  logic accept, load_px, last_px;
  logic [OUT_W-1:0] odata;
  logic             olast, ovalid;

  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
    clamp = (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // setup geometry
  always_comb begin
    adx     = (ax > bx) ? ax - bx : bx - ax;
    ady     = (ay > by) ? ay - by : by - ay;
    steep_w = adx < ady;
    p0maj   = steep_w ? ay : ax;
    p0mnr   = steep_w ? ax : ay;
    p1maj   = steep_w ? by : bx;
    p1mnr   = steep_w ? bx : by;
    if (p0maj > p1maj) begin
      smaj = p1maj; smnr = p1mnr; emaj = p0maj; emnr = p0mnr;
    end else begin
      smaj = p0maj; smnr = p0mnr; emaj = p1maj; emnr = p1mnr;
    end
  end

  blw_step u_step (
    .ctl      (ctl),
    .err      (err),
    .mnr      (mnr),
    .err_next (err_next),
    .mnr_next (mnr_next)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_WALK;
      ST_WALK:  if (load_px && last_px) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    load_px  = (state == ST_WALK) && (!ovalid || m_tready);
  end

  assign accept  = s_tvalid && s_tready;
  assign last_px = (maj == end_maj);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax    <= clamp(s_tdata[5:0]);
      ay    <= clamp(s_tdata[11:6]);
      bx    <= clamp(s_tdata[17:12]);
      by    <= clamp(s_tdata[23:18]);
      red   <= s_tdata[31:24];
      green <= s_tdata[39:32];
      blue  <= s_tdata[47:40];
    end
    if (state == ST_SETUP) begin
      steep    <= steep_w;
      maj      <= smaj;
      mnr      <= smnr;
      end_maj  <= emaj;
      err      <= '0;
      ctl.dx   <= emaj - smaj;
      ctl.derr <= {((emnr > smnr) ? emnr - smnr : smnr - emnr), 1'b0};
      ctl.up   <= emnr > smnr;
    end else if (load_px) begin
      maj <= maj + COORD_W'(1);
      mnr <= mnr_next;
      err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_px) begin
      odata <= {4'b0000, blue, green, red,
                steep ? maj : mnr,
                steep ? mnr : maj};
      olast <= last_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load_px) begin
      ovalid <= 1'b1;
    end else if (m_tready) begin
      ovalid <= 1'b0;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = odata;
  assign m_tlast  = olast;

  `ASSERT_NEXT(a_accept_setup, accept, state == ST_SETUP, "setup did not follow accept")
  `ASSERT_IMPL(a_err_bound, state == ST_WALK, err <= $signed({3'b000, ctl.dx}), "err above dx")
  `ASSERT_IMPL(a_maj_bound, state == ST_WALK, maj <= end_maj, "walk passed end point")

endmodule

>>> rtl/blw_step.sv
// Error-term step unit: one add, compare and subtract per pixel, and the minor coordinate step.
// Depends on blw_pkg.
module blw_step (
  input  blw_pkg::walk_ctl_t                  ctl,
  input  logic signed [blw_pkg::ERR_W-1:0]    err,
  input  logic        [blw_pkg::COORD_W-1:0]  mnr,
  output logic signed [blw_pkg::ERR_W-1:0]    err_next,
  output logic        [blw_pkg::COORD_W-1:0]  mnr_next
);
  import blw_pkg::*;

  logic signed [ERR_W-1:0] sum;
  logic signed [ERR_W-1:0] dx_s;
  logic signed [ERR_W-1:0] dx2_s;

  assign dx_s  = $signed({{(ERR_W-COORD_W){1'b0}}, ctl.dx});
  assign dx2_s = $signed({{(ERR_W-COORD_W-1){1'b0}}, ctl.dx, 1'b0});
  assign sum   = err + $signed({{(ERR_W-COORD_W-1){1'b0}}, ctl.derr});

  always_comb begin
    if (sum > dx_s) begin
      err_next = sum - dx2_s;
      mnr_next = ctl.up ? mnr + COORD_W'(1) : mnr - COORD_W'(1);
    end else begin
      err_next = sum;
      mnr_next = mnr;
    end
  end

endmodule
